[hdl/gru_pkg.sv]
// Package for the Givens rotation unit: widths, sequencer states, helpers.
// No dependencies.
`default_nettype none
package gru_pkg;
  localparam int DataW = 32;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIV   = 9'b000000010,
    ST_SQRT  = 9'b000000100,
    ST_RECIP = 9'b000001000,
    ST_PMUL  = 9'b000010000,
    ST_MUL0  = 9'b000100000,
    ST_MUL1  = 9'b001000000,
    ST_SUM   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iter_ctl_t;
endpackage
`default_nettype wire

[hdl/gru_iter.sv]
// Shared iterative unit: restoring divider (one quotient bit a cycle) or
// digit-by-digit integer square root (one result bit a cycle).
// Depends on gru_pkg.
`default_nettype none
module gru_iter import gru_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire iter_ctl_t   ctl,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic [63:0]      res,
  output logic             done
);
  logic [63:0] rem, q, dv;
  logic [6:0]  cnt;
  logic        busy, sq;
  logic [64:0] trial;
  logic [63:0] root_bit, sq_trial;
  logic [64:0] shifted;

  // divider: remainder shift in one numerator bit
  assign shifted  = {rem, q[63]};
  assign trial    = shifted - {1'b0, dv};
  assign root_bit = 64'd1 << {cnt[5:0], 1'b0};
  assign sq_trial = res + root_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        sq   <= ctl.sqrt_mode;
        rem  <= ctl.sqrt_mode ? num : 64'd0;
        q    <= ctl.sqrt_mode ? 64'd0 : num;
        dv   <= den;
        res  <= '0;
        cnt  <= ctl.sqrt_mode ? 7'd31 : 7'd63;
      end else if (busy) begin
        if (sq) begin
          if (rem >= sq_trial) begin
            rem <= rem - sq_trial;
            res <= (res >> 1) + root_bit;
          end else begin
            res <= res >> 1;
          end
        end else begin
          q <= {q[62:0], 1'b0};
          if (!trial[64]) begin
            rem <= trial[63:0];
            res <= {res[62:0], 1'b1};
          end else begin
            rem <= shifted[63:0];
            res <= {res[62:0], 1'b0};
          end
        end
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("iterative unit restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");
`endif
endmodule
`default_nettype wire

[hdl/givens_rotation_unit.sv]
// Top level of the Givens rotation unit: sequencer, rotation table,
// multiplier and output register. Depends on gru_pkg and gru_iter.
// Usage:
//  Input channel in_valid/in_stall carries mode, slot, x_val, y_val.
//  Output channel out_valid/out_stall carries x_out, y_out, cos_out, sin_out.
//  One word in, one word out. The block takes a word only when idle and
//  its output register is empty or being taken.
//  Generate with y zero goes straight to the four products; apply first
//  passes through ST_MUL0 for the registered table read.
//  Other generates run the shared divide/sqrt unit three times
//  (divide, sqrt, reciprocal, with hand-over) and then form the
//  sine/cosine product, the four products and the output.
//  That unit sets the rate; the next word can be taken in the cycle the
//  result appears, unless out_stall holds it. The four product terms share
//  one 33x33 signed multiplier, one term per step of ST_MUL1.
//  Reset empties the output register and idles the sequencer; the
//  rotation table is not cleared and an unwritten slot reads undefined.
//  With out_valid and out_stall set the result holds; no new word is taken.
`default_nettype none
module givens_rotation_unit import gru_pkg::*; #(
  parameter int SLOTS    = 32,
  parameter int ROT_FRAC = 30
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              mode,
  input  wire logic [4:0]        slot,
  input  wire logic signed [31:0] x_val,
  input  wire logic signed [31:0] y_val,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [31:0]     x_out,
  output logic signed [31:0]     y_out,
  output logic signed [31:0]     cos_out,
  output logic signed [31:0]     sin_out
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t state;
  logic [63:0] tab [SLOTS];
  logic [IW-1:0] idx;
  logic gen;
  logic signed [31:0] xr, yr;
  logic signed [32:0] cr, sr;
  logic [63:0] t, m, tmp;
  logic neg, ybig;
  logic [1:0] step;
  logic signed [65:0] acc_x, acc_y;
  logic signed [65:0] prod;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  iter_ctl_t ctl;
  logic [63:0] num, den, ires;
  logic idone, take;
  logic [31:0] ax, ay;
  logic [63:0] tabrd;
  logic [63:0] pm;

  gru_iter u_iter (
    .clk(clk), .rst(rst), .ctl(ctl), .num(num), .den(den), .res(ires), .done(idone)
  );

  assign in_stall = !(state == ST_IDLE) || (out_valid && out_stall);
  assign take = in_valid && !in_stall;
  assign ax = xr[31] ? 32'(-xr) : xr;
  assign ay = yr[31] ? 32'(-yr) : yr;
  // t and m both stay within 31 bits
  assign pm = (t[31:0] * m[31:0]) >> ROT_FRAC;

  function automatic logic signed [31:0] rsat(input logic signed [65:0] v);
    logic signed [65:0] q;
    q = (v + (66'sd1 <<< (ROT_FRAC - 1))) >>> ROT_FRAC;
    if (q > 66'sd2147483647) return 32'sh7fffffff;
    if (q < -66'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      2'd0: begin ma = cr; mb = {xr[31], xr}; end
      2'd1: begin ma = sr; mb = {yr[31], yr}; end
      2'd2: begin ma = cr; mb = {yr[31], yr}; end
      default: begin ma = sr; mb = {xr[31], xr}; end
    endcase
  end
  assign prod = 66'(ma * mb);

  always_comb begin
    ctl = '0;
    num = '0;
    den = '0;
    case (state)
      ST_DIV: begin
        ctl.start = (step == 2'd0);
        num = (ay > ax) ? ({32'd0, ax} << ROT_FRAC) : ({32'd0, ay} << ROT_FRAC);
        den = (ay > ax) ? {32'd0, ay} : {32'd0, ax};
      end
      ST_SQRT: begin
        ctl.start = (step == 2'd0);
        ctl.sqrt_mode = 1'b1;
        num = (64'd1 << (2 * ROT_FRAC)) + t[31:0] * t[31:0];
      end
      ST_RECIP: begin
        ctl.start = (step == 2'd0);
        num = 64'd1 << (2 * ROT_FRAC);
        den = tmp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!gen && state == ST_MUL0 && step == 2'd0) tabrd <= tab[idx];
    if (state == ST_SUM && gen) tab[idx] <= {cr[31:0], sr[31:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (out_valid && !out_stall && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (take) begin
          idx  <= IW'(slot % SLOTS);
          gen  <= !mode;
          xr   <= x_val;
          yr   <= y_val;
          neg  <= x_val[31] ^ y_val[31];
          step <= '0;
          if (mode) state <= ST_MUL0;
          else if (y_val == 32'sd0) begin
            cr <= 33'sd1 <<< ROT_FRAC;
            sr <= '0;
            state <= ST_MUL1;
          end else state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == 2'd0) begin
            ybig <= ay > ax;
            step <= 2'd1;
          end
          if (idone) begin
            t <= ires;
            step <= 2'd0;
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (idone) begin
            tmp <= ires;
            step <= 2'd0;
            state <= ST_RECIP;
          end else begin
            step <= 2'd1;
          end
        end
        ST_RECIP: begin
          if (idone) begin
            m <= ires;
            step <= 2'd0;
            state <= ST_PMUL;
          end else begin
            step <= 2'd1;
          end
        end
        ST_PMUL: begin
          if (ybig) begin
            sr <= 33'(m);
            cr <= neg ? -33'(pm) : 33'(pm);
          end else begin
            cr <= 33'(m);
            sr <= neg ? -33'(pm) : 33'(pm);
          end
          state <= ST_MUL1;
        end
        ST_MUL0: begin
          // step 0 issues the registered table read; step 1 loads cr and sr
          if (step == 2'd0) step <= 2'd1;
          else begin
            cr <= {tabrd[63], tabrd[63:32]};
            sr <= {tabrd[31], tabrd[31:0]};
            step <= 2'd0;
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          case (step)
            2'd0: acc_x <= prod;
            2'd1: acc_x <= acc_x + prod;
            2'd2: acc_y <= prod;
            default: acc_y <= acc_y - prod;
          endcase
          step <= step + 2'd1;
          if (step == 2'd3) state <= ST_SUM;
        end
        ST_SUM: state <= ST_OUT;
        ST_OUT: if (!out_valid || !out_stall) begin
          x_out   <= rsat(acc_x);
          y_out   <= rsat(acc_y);
          cos_out <= cr[31:0];
          sin_out <= sr[31:0];
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("word taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT)) else $error("stray result");
`endif
endmodule
`default_nettype wire

[verif/tb_givens_rotation_unit.sv]
`timescale 1ns / 1ps
// Testbench for givens_rotation_unit: directed table then random pairs, each result
// checked vs table word or behavioural rotation predictor. Depends on gru_pkg, RTL.
module tb_givens_rotation_unit;
  import gru_pkg::*;

  localparam int RotFrac = 30;
  localparam int NSlots = 32;
  localparam logic GenMode = 1'b0;
  localparam logic ApplyMode = 1'b1;
  localparam logic signed [31:0] One = 32'sd1073741824;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = GenMode;
  logic [4:0] slot = '0;
  logic signed [31:0] x_val = '0;
  logic signed [31:0] y_val = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] x_out, y_out, cos_out, sin_out;

  typedef struct {
    logic signed [31:0] xo, yo, c, s;
  } rot_word_t;

  typedef struct {
    logic md;
    logic [4:0] sl;
    logic signed [31:0] x, y;
    logic known;
    rot_word_t res;
  } stim_row_t;

  rot_word_t expected_q[$];
  longint cos_store[NSlots];
  longint sin_store[NSlots];
  bit slot_written[NSlots];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  givens_rotation_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("tb_givens_rotation_unit NOT OK");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned u);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > u) b = b >> 2;
    while (b != 0) begin
      if (u >= res + b) begin
        u = u - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] round_clip(longint v);
    longint q;
    q = (v + (64'sd1 << (RotFrac - 1))) >>> RotFrac;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // updates the slot store on generate
  function automatic rot_word_t rotate_pair(logic md, logic [4:0] sl,
                                            logic signed [31:0] xi, logic signed [31:0] yi);
    rot_word_t r;
    longint x, y, c, s, sp;
    longint unsigned ax, ay, big, sml, t, u, rt, m, p;
    x = xi;
    y = yi;
    if (md == GenMode) begin
      if (y == 0) begin
        c = 64'sd1 << RotFrac;
        s = 0;
      end else begin
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        big = ay > ax ? ay : ax;
        sml = ay > ax ? ax : ay;
        t = (sml << RotFrac) / big;
        u = (64'd1 << (2 * RotFrac)) + t * t;
        rt = int_sqrt(u);
        m = (64'd1 << (2 * RotFrac)) / rt;
        p = (t * m) >> RotFrac;
        sp = ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
        if (ay > ax) begin
          s = m;
          c = sp;
        end else begin
          c = m;
          s = sp;
        end
      end
      cos_store[sl] = c;
      sin_store[sl] = s;
      slot_written[sl] = 1'b1;
    end else begin
      c = cos_store[sl];
      s = sin_store[sl];
    end
    r.xo = round_clip(c * x + s * y);
    r.yo = round_clip(c * y - s * x);
    r.c = c[31:0];
    r.s = s[31:0];
    return r;
  endfunction

  // valid stays up between back-to-back words; callers drop it before pausing
  task automatic send_word(logic md, logic [4:0] sl, logic signed [31:0] x,
                           logic signed [31:0] y, logic known, rot_word_t res);
    rot_word_t p;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    p = rotate_pair(md, sl, x, y);
    if (known) p = res;
    mode <= md;
    slot <= sl;
    x_val <= x;
    y_val <= y;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(p);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    rot_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (x_out !== e.xo) begin
          $error("x_out exp %0d got %0d", e.xo, x_out); errors++;
        end
        if (y_out !== e.yo) begin
          $error("y_out exp %0d got %0d", e.yo, y_out); errors++;
        end
        if (cos_out !== e.c) begin
          $error("cos_out exp %0d got %0d", e.c, cos_out); errors++;
        end
        if (sin_out !== e.s) begin
          $error("sin_out exp %0d got %0d", e.s, sin_out); errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_data();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(8191)) - 4096;
      2: return 32'sh7fffffff - $urandom_range(3);
      3: return 32'sh80000000 + $urandom_range(3);
      4: return 0;
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [4:0] sl;
    logic signed [31:0] x, y;
    rot_word_t none;
    for (int i = 0; i < n; i++) begin
      sl = 5'($urandom);
      x = rand_data();
      y = rand_data();
      // applies only to slots already generated
      if ($urandom_range(99) < 45 && slot_written[sl])
        send_word(ApplyMode, sl, x, y, 1'b0, none);
      else
        send_word(GenMode, sl, x, y, 1'b0, none);
    end
  endtask

  initial begin
    stim_row_t tbl[$];
    rot_word_t none;
    int guard;
    tbl = '{
      '{GenMode, 5'd0, 32'sd65536, 32'sd0, 1'b1,
        '{32'sd65536, 32'sd0, One, 32'sd0}},
      '{GenMode, 5'd31, 32'sh80000000, 32'sd0, 1'b1,
        '{32'sh80000000, 32'sd0, One, 32'sd0}},
      '{GenMode, 5'd1, 32'sh7fffffff, 32'sd0, 1'b1,
        '{32'sh7fffffff, 32'sd0, One, 32'sd0}},
      '{ApplyMode, 5'd0, 32'sh80000000, 32'sh7fffffff, 1'b1,
        '{32'sh80000000, 32'sh7fffffff, One, 32'sd0}},
      '{GenMode, 5'd2, 32'sd0, 32'sd65536, 1'b0, none},
      '{GenMode, 5'd3, 32'sd65536, 32'sd65536, 1'b0, none},
      '{GenMode, 5'd4, -32'sd65536, 32'sd65536, 1'b0, none},
      '{GenMode, 5'd5, 32'sh80000000, 32'sh80000000, 1'b0, none},
      '{GenMode, 5'd6, 32'sh7fffffff, 32'sh80000000, 1'b0, none},
      '{GenMode, 5'd7, 32'sd1, -32'sd1, 1'b0, none},
      '{GenMode, 5'd8, 32'sd1, 32'sh7fffffff, 1'b0, none},
      '{GenMode, 5'd9, 32'sh80000000, 32'sd1, 1'b0, none},
      '{ApplyMode, 5'd3, 32'sh7fffffff, 32'sh7fffffff, 1'b0, none},
      '{ApplyMode, 5'd4, 32'sh80000000, 32'sh7fffffff, 1'b0, none},
      '{ApplyMode, 5'd2, 32'sh7fffffff, 32'sh80000000, 1'b0, none},
      '{ApplyMode, 5'd31, 32'sd123456, -32'sd98765, 1'b0, none},
      '{ApplyMode, 5'd7, 32'sh55555555, 32'shaaaaaaaa, 1'b0, none}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (tbl[i])
      send_word(tbl[i].md, tbl[i].sl, tbl[i].x, tbl[i].y, tbl[i].known, tbl[i].res);
    send_idle_pct = 16;
    recv_idle_pct = 70;
    random_phase(500);
    // long receiver hold-off while words keep coming
    hold_off = 600;
    random_phase(20);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    @(negedge clk);
    send_idle_pct = 70;
    recv_idle_pct = 16;
    random_phase(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(600);
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_givens_rotation_unit OK");
    end else begin
      $display("tb_givens_rotation_unit NOT OK");
    end
    $finish;
  end
endmodule
